@@ rtl/est_pkg.sv @@
package est_pkg;

   localparam int unsigned FR_DEPTH = 15;
   localparam int unsigned DV_DEPTH = 32;
   localparam int unsigned BK_DEPTH = 3;

   localparam logic [19:0] SKIP_TP = 20'h80000;
   localparam logic [15:0] SKIP_H  = 16'h8000;

   localparam logic [31:0] HUM_CAP = 32'd419430400;

   localparam int unsigned CSR_AW = 6;
   localparam int unsigned CSR_DW = 64;

   typedef enum logic [2:0] {
      REG_TEMP      = 3'd0,
      REG_PRESS_A   = 3'd1,
      REG_PRESS_B   = 3'd2,
      REG_PRESS_LST = 3'd3,
      REG_HUM       = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
   } trim_type;

   typedef struct packed {
      logic [19:0] rt;
      logic [19:0] rp;
      logic [15:0] rh;
   } raw_type;

   typedef struct packed {
      logic [19:0] rt;
      logic [19:0] rp;
      logic [15:0] rh;
      logic [31:0] a1, dt, m1, m2, v1, m3, tf, temp, pv1, hv;
      logic [31:0] q2, mp5, mp2, hm5, hm6, hm3, v2a, mp3, ha, hb1;
      logic [31:0] v2, pv1b, hb2, x, hbm, pnum, dvs, pp, hb, hv2, hd, hsq, hh;
      logic [16:0] hum;
   } fr_type;

   typedef struct packed {
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] rem;
      logic [31:0] quo;
      logic        post;
      logic        zero;
      logic [31:0] temp;
      logic [16:0] hum;
   } dv_type;

   typedef struct packed {
      logic [31:0] p;
      logic [31:0] sq;
      logic [31:0] p8m;
      logic [31:0] pv1;
      logic [31:0] pv2;
      logic [31:0] pres;
      logic        zero;
      logic [31:0] temp;
      logic [16:0] hum;
   } bk_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] w);
      return {{16{w[15]}}, w};
   endfunction

endpackage

@@ rtl/est_req_if.sv @@
interface est_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;
   logic [15:0] raw_humidity;

   modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
   modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

@@ rtl/est_rsp_if.sv @@
interface est_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] temperature_centi;
   logic [31:0] pressure_pa;
   logic [16:0] humidity_q10;

   modport source (output valid, temperature_centi, pressure_pa, humidity_q10, input ready);
   modport sink (input valid, temperature_centi, pressure_pa, humidity_q10, output ready);
endinterface

@@ rtl/est_front.sv @@
module est_front (
   input  logic              clock,
   input  logic              reset,
   input  est_pkg::trim_type trim,
   input  logic              in_valid,
   output logic              in_ready,
   input  est_pkg::raw_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output est_pkg::fr_type   out_data
);
   import est_pkg::*;

   logic   [FR_DEPTH-1:0] v_ff;
   fr_type                d_ff  [FR_DEPTH];
   fr_type                d_in  [FR_DEPTH];
   logic   [FR_DEPTH:0]   adv;
   logic   [FR_DEPTH-1:0] src_v;
   logic   [31:0]         hf;

   always_comb begin
      adv[FR_DEPTH] = out_ready;
      for (int k = FR_DEPTH - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      src_v = {v_ff[FR_DEPTH-2:0], in_valid};
   end

   always_comb begin
      for (int k = 1; k < FR_DEPTH; k++) begin
         d_in[k] = d_ff[k-1];
      end
      d_in[0]    = d_ff[0];
      d_in[0].rt = in_data.rt;
      d_in[0].rp = in_data.rp;
      d_in[0].rh = in_data.rh;
      d_in[0].a1 = ({12'd0, in_data.rt} >> 3) - (trim.t1 << 1);
      d_in[0].dt = ({12'd0, in_data.rt} >> 4) - trim.t1;

      d_in[1].m1 = d_ff[0].a1 * trim.t2;
      d_in[1].m2 = d_ff[0].dt * d_ff[0].dt;

      d_in[2].v1 = asr(d_ff[1].m1, 11);
      d_in[2].m3 = asr(d_ff[1].m2, 12) * trim.t3;

      d_in[3].tf = d_ff[2].v1 + asr(d_ff[2].m3, 14);

      d_in[4].temp = asr(d_ff[3].tf * 32'd5 + 32'd128, 8);
      if (d_ff[3].rt == SKIP_TP) begin
         d_in[4].temp = '0;
      end
      d_in[4].pv1 = asr(d_ff[3].tf, 1) - 32'd64000;
      d_in[4].hv  = d_ff[3].tf - 32'd76800;

      d_in[5].q2  = asr(d_ff[4].pv1, 2) * asr(d_ff[4].pv1, 2);
      d_in[5].mp5 = d_ff[4].pv1 * trim.p5;
      d_in[5].mp2 = trim.p2 * d_ff[4].pv1;
      d_in[5].hm5 = trim.h5 * d_ff[4].hv;
      d_in[5].hm6 = d_ff[4].hv * trim.h6;
      d_in[5].hm3 = d_ff[4].hv * trim.h3;

      d_in[6].v2a = asr(d_ff[5].q2, 11) * trim.p6;
      d_in[6].mp3 = trim.p3 * asr(d_ff[5].q2, 13);
      d_in[6].ha  = asr(({16'd0, d_ff[5].rh} << 14) - (trim.h4 << 20) - d_ff[5].hm5
                        + 32'd16384, 15);
      d_in[6].hb1 = asr(d_ff[5].hm6, 10) * (asr(d_ff[5].hm3, 11) + 32'd32768);

      d_in[7].v2   = asr(d_ff[6].v2a + (d_ff[6].mp5 << 1), 2) + (trim.p4 << 16);
      d_in[7].pv1b = asr(asr(d_ff[6].mp3, 3) + asr(d_ff[6].mp2, 1), 18);
      d_in[7].hb2  = asr(d_ff[6].hb1, 10) + 32'd2097152;

      d_in[8].x    = (32'd32768 + d_ff[7].pv1b) * trim.p1;
      d_in[8].hbm  = d_ff[7].hb2 * trim.h2;
      d_in[8].pnum = (32'd1048576 - {12'd0, d_ff[7].rp}) - asr(d_ff[7].v2, 12);

      d_in[9].dvs = asr(d_ff[8].x, 15);
      d_in[9].pp  = d_ff[8].pnum * 32'd3125;
      d_in[9].hb  = asr(d_ff[8].hbm + 32'd8192, 14);

      d_in[10].hv2 = d_ff[9].ha * d_ff[9].hb;

      d_in[11].hd = asr(d_ff[10].hv2, 15);

      d_in[12].hsq = d_ff[11].hd * d_ff[11].hd;

      d_in[13].hh = asr(d_ff[12].hsq, 7) * trim.h1;

      // clamp to 0..HUM_CAP before dropping the fraction
      hf = d_ff[13].hv2 - asr(d_ff[13].hh, 4);
      if (hf[31]) begin
         hf = '0;
      end
      if (hf > HUM_CAP) begin
         hf = HUM_CAP;
      end
      d_in[14].hum = hf[28:12];
      if (d_ff[13].rh == SKIP_H) begin
         d_in[14].hum = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < FR_DEPTH; k++) begin
         if (adv[k]) begin
            if (src_v[k]) begin
               d_ff[k] <= d_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < FR_DEPTH; k++) begin
            if (adv[k]) begin
               v_ff[k] <= src_v[k];
            end
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[FR_DEPTH-1];
   assign out_data  = d_ff[FR_DEPTH-1];
endmodule

@@ rtl/est_div.sv @@
module est_div (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  est_pkg::fr_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output est_pkg::dv_type out_data
);
   import est_pkg::*;

   logic   [DV_DEPTH-1:0] v_ff;
   dv_type                d_ff  [DV_DEPTH];
   dv_type                d_in  [DV_DEPTH];
   dv_type                src   [DV_DEPTH];
   logic   [DV_DEPTH:0]   adv;
   logic   [DV_DEPTH-1:0] src_v;
   logic   [32:0]         trial [DV_DEPTH];
   logic   [DV_DEPTH-1:0] ge;

   always_comb begin
      adv[DV_DEPTH] = out_ready;
      for (int k = DV_DEPTH - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      src_v = {v_ff[DV_DEPTH-2:0], in_valid};
   end

   always_comb begin
      // set up: double the dividend up front unless that would overflow
      src[0].den  = in_data.dvs;
      src[0].rem  = '0;
      src[0].quo  = '0;
      src[0].post = in_data.pp[31];
      src[0].num  = in_data.pp[31] ? in_data.pp : (in_data.pp << 1);
      src[0].zero = (in_data.dvs == '0) || (in_data.rp == SKIP_TP);
      src[0].temp = in_data.temp;
      src[0].hum  = in_data.hum;
      for (int k = 1; k < DV_DEPTH; k++) begin
         src[k] = d_ff[k-1];
      end
      // one quotient bit per stage
      for (int k = 0; k < DV_DEPTH; k++) begin
         trial[k]    = {src[k].rem, src[k].num[31]};
         ge[k]       = trial[k] >= {1'b0, src[k].den};
         d_in[k]     = src[k];
         d_in[k].rem = ge[k] ? 32'(trial[k] - {1'b0, src[k].den}) : trial[k][31:0];
         d_in[k].quo = {src[k].quo[30:0], ge[k]};
         d_in[k].num = src[k].num << 1;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DV_DEPTH; k++) begin
         if (adv[k]) begin
            if (src_v[k]) begin
               d_ff[k] <= d_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < DV_DEPTH; k++) begin
            if (adv[k]) begin
               v_ff[k] <= src_v[k];
            end
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[DV_DEPTH-1];
   assign out_data  = d_ff[DV_DEPTH-1];
endmodule

@@ rtl/est_back.sv @@
module est_back (
   input  logic              clock,
   input  logic              reset,
   input  est_pkg::trim_type trim,
   input  logic              in_valid,
   output logic              in_ready,
   input  est_pkg::dv_type   in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output est_pkg::bk_type   out_data
);
   import est_pkg::*;

   logic   [BK_DEPTH-1:0] v_ff;
   bk_type                d_ff  [BK_DEPTH];
   bk_type                d_in  [BK_DEPTH];
   logic   [BK_DEPTH:0]   adv;
   logic   [BK_DEPTH-1:0] src_v;
   logic   [31:0]         p;

   always_comb begin
      adv[BK_DEPTH] = out_ready;
      for (int k = BK_DEPTH - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      src_v = {v_ff[BK_DEPTH-2:0], in_valid};
   end

   always_comb begin
      p = in_data.post ? (in_data.quo << 1) : in_data.quo;
      d_in[0]      = d_ff[0];
      d_in[0].p    = p;
      d_in[0].sq   = (p >> 3) * (p >> 3);
      d_in[0].p8m  = (p >> 2) * trim.p8;
      d_in[0].zero = in_data.zero;
      d_in[0].temp = in_data.temp;
      d_in[0].hum  = in_data.hum;

      d_in[1]     = d_ff[0];
      d_in[1].pv1 = asr(trim.p9 * (d_ff[0].sq >> 13), 12);
      d_in[1].pv2 = asr(d_ff[0].p8m, 13);

      d_in[2]      = d_ff[1];
      d_in[2].pres = d_ff[1].zero ? '0
                   : d_ff[1].p + asr(d_ff[1].pv1 + d_ff[1].pv2 + trim.p7, 4);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < BK_DEPTH; k++) begin
         if (adv[k]) begin
            if (src_v[k]) begin
               d_ff[k] <= d_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < BK_DEPTH; k++) begin
            if (adv[k]) begin
               v_ff[k] <= src_v[k];
            end
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[BK_DEPTH-1];
   assign out_data  = d_ff[BK_DEPTH-1];
endmodule

@@ rtl/env_sensor_trim_compensation.sv @@
// Stages from an accepted word to its result word: 15 front stages, 32 divider
// stages, 3 back stages with the output register last. Throughput: one word per
// cycle while the result is not stalled; the 32-stage restoring divider sets the depth.
// Each stage advances on its own, so bubbles collapse behind a stalled result.
// Reset (synchronous, active high) clears all stage valid bits and the trim registers.
module env_sensor_trim_compensation (
   input  logic                        clock,
   input  logic                        reset,
   est_req_if.sink                     req_bus,
   est_rsp_if.source                   rsp_bus,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [est_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [est_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [est_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import est_pkg::*;

   logic [47:0] temp_trim_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [15:0] press_lst_ff;
   logic [63:0] hum_trim_ff;

   reg_idx_type csr_idx;
   logic        csr_wr;
   trim_type    trim;
   raw_type     raw;

   logic   fr_valid, fr_ready;
   fr_type fr_data;
   logic   dv_valid, dv_ready;
   dv_type dv_data;
   bk_type bk_data;

   // registers sit on 8-byte boundaries
   assign csr_idx    = reg_idx_type'(csr_paddr[5:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff <= '0;
         press_a_ff   <= '0;
         press_b_ff   <= '0;
         press_lst_ff <= '0;
         hum_trim_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_TEMP:      temp_trim_ff <= csr_pwdata[47:0];
            REG_PRESS_A:   press_a_ff   <= csr_pwdata;
            REG_PRESS_B:   press_b_ff   <= csr_pwdata;
            REG_PRESS_LST: press_lst_ff <= csr_pwdata[15:0];
            REG_HUM:       hum_trim_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_TEMP:      csr_prdata = {16'd0, temp_trim_ff};
         REG_PRESS_A:   csr_prdata = press_a_ff;
         REG_PRESS_B:   csr_prdata = press_b_ff;
         REG_PRESS_LST: csr_prdata = {48'd0, press_lst_ff};
         REG_HUM:       csr_prdata = hum_trim_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // unpack the calibration words into 32-bit two's complement patterns
   always_comb begin
      trim.t1 = {16'd0, temp_trim_ff[15:0]};
      trim.t2 = sx16(temp_trim_ff[31:16]);
      trim.t3 = sx16(temp_trim_ff[47:32]);
      trim.p1 = {16'd0, press_a_ff[15:0]};
      trim.p2 = sx16(press_a_ff[31:16]);
      trim.p3 = sx16(press_a_ff[47:32]);
      trim.p4 = sx16(press_a_ff[63:48]);
      trim.p5 = sx16(press_b_ff[15:0]);
      trim.p6 = sx16(press_b_ff[31:16]);
      trim.p7 = sx16(press_b_ff[47:32]);
      trim.p8 = sx16(press_b_ff[63:48]);
      trim.p9 = sx16(press_lst_ff);
      trim.h1 = {24'd0, hum_trim_ff[7:0]};
      trim.h2 = sx16(hum_trim_ff[23:8]);
      trim.h3 = {24'd0, hum_trim_ff[31:24]};
      trim.h4 = {{20{hum_trim_ff[43]}}, hum_trim_ff[43:32]};
      trim.h5 = {{20{hum_trim_ff[55]}}, hum_trim_ff[55:44]};
      trim.h6 = {{24{hum_trim_ff[63]}}, hum_trim_ff[63:56]};
   end

   assign raw.rt = req_bus.raw_temperature;
   assign raw.rp = req_bus.raw_pressure;
   assign raw.rh = req_bus.raw_humidity;

   // temperature, fine value, pressure terms and the full humidity chain
   est_front u_front (
      .clock     (clock),
      .reset     (reset),
      .trim      (trim),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (raw),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_data  (fr_data)
   );

   // pressure quotient, one bit per stage
   est_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_data  (dv_data)
   );

   // pressure correction terms; last stage is the output register
   est_back u_back (
      .clock     (clock),
      .reset     (reset),
      .trim      (trim),
      .in_valid  (dv_valid),
      .in_ready  (dv_ready),
      .in_data   (dv_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (bk_data)
   );

   assign rsp_bus.temperature_centi = bk_data.temp;
   assign rsp_bus.pressure_pa       = bk_data.pres;
   assign rsp_bus.humidity_q10      = bk_data.hum;
endmodule

@@ rtl/est_chk.sv @@
module est_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_temperature_centi,
   input logic [31:0] rsp_pressure_pa,
   input logic [16:0] rsp_humidity_q10,
   input logic        csr_pready
);
   a_rst_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature_centi)
         && $stable(rsp_pressure_pa) && $stable(rsp_humidity_q10))
      else $error("stalled result word changed");

   a_hum_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_q10 <= 17'd102400)
      else $error("humidity out of range");

   a_pready : assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr pready low");
endmodule

bind env_sensor_trim_compensation est_chk u_est_chk (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_bus.valid),
   .rsp_ready             (rsp_bus.ready),
   .rsp_temperature_centi (rsp_bus.temperature_centi),
   .rsp_pressure_pa       (rsp_bus.pressure_pa),
   .rsp_humidity_q10      (rsp_bus.humidity_q10),
   .csr_pready            (csr_pready)
);
